### sv/assembly_source_tokenizer_unit_defines.svh
// assertion helpers for the checks in the tokenizer top
`ifndef ASSEMBLY_SOURCE_TOKENIZER_UNIT_DEFINES_SVH
`define ASSEMBLY_SOURCE_TOKENIZER_UNIT_DEFINES_SVH

// same-cycle implication, off while reset is high
`define ASTU_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tokenizer check failed");

// next-cycle implication, off while reset is high
`define ASTU_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tokenizer check failed");

`endif

### sv/astu_pkg.sv
package astu_pkg;

   typedef enum logic [2:0] {
      MODE_IDLE    = 3'd0,
      MODE_COMMENT = 3'd1,
      MODE_STRING  = 3'd2,
      MODE_SIGN    = 3'd3,
      MODE_ZERO    = 3'd4,
      MODE_BODY    = 3'd5,
      MODE_IDENT   = 3'd6,
      MODE_ERROR   = 3'd7
   } mode_type;

   localparam logic [3:0] KIND_END    = 4'd0;
   localparam logic [3:0] KIND_DOT    = 4'd1;
   localparam logic [3:0] KIND_COMMA  = 4'd2;
   localparam logic [3:0] KIND_COLON  = 4'd3;
   localparam logic [3:0] KIND_LSQ    = 4'd4;
   localparam logic [3:0] KIND_RSQ    = 4'd5;
   localparam logic [3:0] KIND_IDENT  = 4'd6;
   localparam logic [3:0] KIND_STRING = 4'd7;
   localparam logic [3:0] KIND_NUMBER = 4'd8;
   localparam logic [3:0] KIND_ERROR  = 4'd9;

   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_QUOTE = 8'h22;
   localparam logic [7:0] CHAR_COMMA = 8'h2C;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_DOT   = 8'h2E;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_COLON = 8'h3A;
   localparam logic [7:0] CHAR_SEMI  = 8'h3B;
   localparam logic [7:0] CHAR_UP_A  = 8'h41;
   localparam logic [7:0] CHAR_UP_Z  = 8'h5A;
   localparam logic [7:0] CHAR_LSQ   = 8'h5B;
   localparam logic [7:0] CHAR_RSQ   = 8'h5D;
   localparam logic [7:0] CHAR_LO_A  = 8'h61;
   localparam logic [7:0] CHAR_LO_B  = 8'h62;
   localparam logic [7:0] CHAR_LO_F  = 8'h66;
   localparam logic [7:0] CHAR_LO_O  = 8'h6F;
   localparam logic [7:0] CHAR_LO_X  = 8'h78;
   localparam logic [7:0] CHAR_LO_Z  = 8'h7A;
   localparam logic [7:0] CASE_GAP   = 8'h20;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [3:0]  kind;
      logic [15:0] start;
      logic [15:0] length;
      logic [7:0]  bad;
   } token_type;

   // results of one character: one or two tokens
   typedef struct packed {
      logic      two;
      token_type first;
      token_type second;
   } job_type;

   function automatic logic [7:0] to_lower(input logic [7:0] c);
      return (c >= CHAR_UP_A && c <= CHAR_UP_Z) ? c + CASE_GAP : c;
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR);
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c >= CHAR_ZERO && c <= CHAR_NINE;
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      logic [7:0] l;
      l = to_lower(c);
      return l >= CHAR_LO_A && l <= CHAR_LO_Z;
   endfunction

   function automatic logic is_hex(input logic [7:0] c);
      logic [7:0] l;
      l = to_lower(c);
      return is_digit(c) || (l >= CHAR_LO_A && l <= CHAR_LO_F);
   endfunction

   function automatic logic is_punct(input logic [7:0] c);
      return c == CHAR_DOT || c == CHAR_COMMA || c == CHAR_COLON ||
             c == CHAR_LSQ || c == CHAR_RSQ;
   endfunction

   function automatic logic [3:0] punct_kind(input logic [7:0] c);
      logic [3:0] k;
      k = KIND_RSQ;
      case (c)
         CHAR_DOT:   k = KIND_DOT;
         CHAR_COMMA: k = KIND_COMMA;
         CHAR_COLON: k = KIND_COLON;
         CHAR_LSQ:   k = KIND_LSQ;
         default:    k = KIND_RSQ;
      endcase
      return k;
   endfunction

endpackage

### sv/astu_front.sv
module astu_front
   import astu_pkg::*;
#(
   parameter int MAX_TEXT_LEN = 65536
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic [7:0] text_char,
   input  logic       final_char,
   output logic       job_push,
   output job_type    job
);

   localparam int POS_W = $clog2(MAX_TEXT_LEN + 1);
   localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_TEXT_LEN);

   mode_type         mode_ff, mode_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [15:0]      open_ff, open_in;

   logic [15:0] pos16;
   logic [15:0] run;
   logic [7:0]  lc;
   logic        rescan;
   logic        first_v, second_v;
   token_type   first, second;

   assign pos16 = 16'(pos_ff);
   assign run   = pos16 - open_ff;
   assign lc    = to_lower(text_char);

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_IDLE;
         pos_ff  <= '0;
         open_ff <= '0;
      end else if (accept) begin
         mode_ff <= mode_in;
         pos_ff  <= pos_in;
         open_ff <= open_in;
      end
   end

   always_comb begin
      mode_in  = mode_ff;
      open_in  = open_ff;
      pos_in   = (pos_ff != POS_MAX) ? pos_ff + POS_W'(1) : pos_ff;
      rescan   = 1'b0;
      first_v  = 1'b0;
      second_v = 1'b0;
      first    = '0;
      second   = '0;

      // close or extend the open token
      unique case (mode_ff)
         MODE_IDLE: begin
            rescan = 1'b1;
         end
         MODE_COMMENT: begin
            if (text_char == CHAR_LF) mode_in = MODE_IDLE;
         end
         MODE_STRING: begin
            if (final_char || text_char == CHAR_QUOTE) begin
               first_v      = 1'b1;
               first.kind   = KIND_STRING;
               first.start  = open_ff;
               first.length = run - 16'd1;
               mode_in      = MODE_IDLE;
            end
         end
         MODE_SIGN, MODE_ZERO, MODE_BODY: begin
            if (!final_char && mode_ff == MODE_SIGN && text_char == CHAR_ZERO) begin
               mode_in = MODE_ZERO;
            end else if (!final_char && mode_ff == MODE_ZERO &&
                         (lc == CHAR_LO_X || lc == CHAR_LO_B || lc == CHAR_LO_O)) begin
               mode_in = MODE_BODY;
            end else if (!final_char && is_hex(text_char)) begin
               mode_in = MODE_BODY;
            end else begin
               first_v      = 1'b1;
               first.kind   = KIND_NUMBER;
               first.start  = open_ff;
               first.length = run;
               mode_in      = MODE_IDLE;
               rescan       = 1'b1;
            end
         end
         MODE_IDENT: begin
            if (final_char || !(is_alpha(text_char) || is_digit(text_char))) begin
               first_v      = 1'b1;
               first.kind   = KIND_IDENT;
               first.start  = open_ff;
               first.length = run;
               mode_in      = MODE_IDLE;
               rescan       = 1'b1;
            end
         end
         MODE_ERROR: begin
            mode_in = MODE_ERROR;
         end
      endcase

      // scan the character from idle
      second.start  = pos16;
      second.length = 16'd1;
      if (rescan && !is_space(text_char)) begin
         open_in = pos16;
         if (text_char == CHAR_NUL) begin
            second_v      = 1'b1;
            second.kind   = KIND_END;
            second.length = 16'd0;
         end else if (text_char == CHAR_SEMI) begin
            mode_in = MODE_COMMENT;
         end else if (is_punct(text_char)) begin
            second_v    = 1'b1;
            second.kind = punct_kind(text_char);
         end else if (text_char == CHAR_QUOTE) begin
            if (final_char) begin
               second_v      = 1'b1;
               second.kind   = KIND_STRING;
               second.length = 16'd0;
            end else begin
               mode_in = MODE_STRING;
            end
         end else if (is_digit(text_char) || text_char == CHAR_MINUS) begin
            if (final_char) begin
               second_v    = 1'b1;
               second.kind = KIND_NUMBER;
            end else if (text_char == CHAR_MINUS) begin
               mode_in = MODE_SIGN;
            end else if (text_char == CHAR_ZERO) begin
               mode_in = MODE_ZERO;
            end else begin
               mode_in = MODE_BODY;
            end
         end else if (is_alpha(text_char)) begin
            if (final_char) begin
               second_v    = 1'b1;
               second.kind = KIND_IDENT;
            end else begin
               mode_in = MODE_IDENT;
            end
         end else begin
            second_v    = 1'b1;
            second.kind = KIND_ERROR;
            second.bad  = text_char;
            mode_in     = MODE_ERROR;
         end
      end

      // terminator restarts the text
      if (final_char) begin
         mode_in = MODE_IDLE;
         pos_in  = '0;
         open_in = '0;
      end
   end

   assign job_push   = accept && (first_v || second_v);
   assign job.two    = first_v && second_v;
   assign job.first  = first_v ? first : second;
   assign job.second = second;

endmodule

### sv/astu_queue.sv
module astu_queue
   import astu_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   output logic    full,
   input  logic    pop,
   output logic    head_valid,
   output job_type head_job
);

   job_type                slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ff, wr_in;
   logic [QUEUE_PTR_W-1:0] rd_ff, rd_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;

   assign full       = count_ff == QUEUE_CNT_W'(QUEUE_DEPTH);
   assign head_valid = count_ff != '0;
   assign head_job   = slot_ff[rd_ff];

   always_comb begin
      wr_in    = push ? wr_ff + QUEUE_PTR_W'(1) : wr_ff;
      rd_in    = pop ? rd_ff + QUEUE_PTR_W'(1) : rd_ff;
      count_in = count_ff + QUEUE_CNT_W'(push) - QUEUE_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ff] <= push_job;
   end

endmodule

### sv/astu_back.sv
module astu_back
   import astu_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        head_valid,
   input  job_type     head_job,
   output logic        head_pop,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [3:0]  rsp_token_kind,
   output logic [15:0] rsp_token_start,
   output logic [15:0] rsp_token_length,
   output logic [7:0]  rsp_bad_char,
   output logic        rsp_last_in_run
);

   token_type out_ff, out_in;
   logic      last_ff, last_in;
   logic      out_valid_ff, out_valid_in;
   token_type spare_ff, spare_in;
   logic      spare_valid_ff, spare_valid_in;
   logic      load;

   // output slot is free or being drained this cycle
   assign load     = !out_valid_ff || rsp_pop;
   assign head_pop = load && !spare_valid_ff && head_valid;

   always_comb begin
      out_in         = out_ff;
      last_in        = last_ff;
      out_valid_in   = out_valid_ff;
      spare_in       = spare_ff;
      spare_valid_in = spare_valid_ff;
      if (load) begin
         if (spare_valid_ff) begin
            out_in         = spare_ff;
            last_in        = 1'b1;
            out_valid_in   = 1'b1;
            spare_valid_in = 1'b0;
         end else if (head_valid) begin
            out_in         = head_job.first;
            last_in        = !head_job.two;
            out_valid_in   = 1'b1;
            spare_in       = head_job.second;
            spare_valid_in = head_job.two;
         end else begin
            out_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff   <= 1'b0;
         spare_valid_ff <= 1'b0;
      end else begin
         out_valid_ff   <= out_valid_in;
         spare_valid_ff <= spare_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff   <= out_in;
      last_ff  <= last_in;
      spare_ff <= spare_in;
   end

   assign rsp_empty        = !out_valid_ff;
   assign rsp_token_kind   = out_ff.kind;
   assign rsp_token_start  = out_ff.start;
   assign rsp_token_length = out_ff.length;
   assign rsp_bad_char     = out_ff.bad;
   assign rsp_last_in_run  = last_ff;

endmodule

### sv/assembly_source_tokenizer_unit.sv
// channel    | direction | handshake            | payload
// req        | in        | req_push / req_full  | text_char, final_char
// rsp        | out       | rsp_pop / rsp_empty  | token_kind, token_start, token_length,
//            |           |                      | bad_char, last_in_run
// one character is taken per cycle while the job queue has room
// the back end hands out one token per cycle while rsp_pop is held; a character that
// closes a number or identifier and is itself a token gives two tokens, handed out in turn
// a four-entry job queue lets the front keep taking characters meanwhile
// synchronous active-high reset clears scan state, position and queues
`include "assembly_source_tokenizer_unit_defines.svh"

module assembly_source_tokenizer_unit
   import astu_pkg::*;
#(
   parameter int MAX_TEXT_LEN = 65536
) (
   input  logic        clock,
   input  logic        reset,
   // character transactions in
   input  logic        req_push,
   output logic        req_full,
   input  logic [7:0]  req_text_char,
   input  logic        req_final_char,
   // token transactions out
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [3:0]  rsp_token_kind,
   output logic [15:0] rsp_token_start,
   output logic [15:0] rsp_token_length,
   output logic [7:0]  rsp_bad_char,
   output logic        rsp_last_in_run
);

   logic    accept;       // character transaction taken this cycle
   logic    job_push;     // front produced at least one token
   job_type job;          // tokens of the current character
   logic    queue_full;
   logic    head_valid;
   job_type head_job;
   logic    head_pop;

   // characters flow in whenever the queue can hold their tokens
   assign accept   = req_push && !req_full;
   assign req_full = queue_full;

   // front: scan state machine, position counter, token forming
   astu_front #(
      .MAX_TEXT_LEN(MAX_TEXT_LEN)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .text_char  (req_text_char),
      .final_char (req_final_char),
      .job_push   (job_push),
      .job        (job)
   );

   // decoupling queue between scanner and token output
   astu_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (job_push),
      .push_job   (job),
      .full       (queue_full),
      .pop        (head_pop),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   // back: splits two-token jobs and holds the output register
   astu_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head_valid       (head_valid),
      .head_job         (head_job),
      .head_pop         (head_pop),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_token_kind   (rsp_token_kind),
      .rsp_token_start  (rsp_token_start),
      .rsp_token_length (rsp_token_length),
      .rsp_bad_char     (rsp_bad_char),
      .rsp_last_in_run  (rsp_last_in_run)
   );

   // the queue never overflows or underflows
   `ASTU_ASSERT_SAME(a_no_overflow, clock, reset, job_push, !queue_full)
   `ASTU_ASSERT_SAME(a_no_underflow, clock, reset, head_pop, head_valid)
   // only a closing number or identifier precedes a second token
   `ASTU_ASSERT_SAME(a_two_first_kind, clock, reset, job_push && job.two,
      job.first.kind == KIND_NUMBER || job.first.kind == KIND_IDENT)
   // an end token is always the last of its character
   `ASTU_ASSERT_SAME(a_end_is_last, clock, reset,
      !rsp_empty && rsp_token_kind == KIND_END, rsp_last_in_run)

endmodule

### tb/token_checker.sv
`timescale 1ns / 1ps

module token_checker
   import astu_pkg::*;
#(
   parameter int TEXT_LIMIT = 65536
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   input  logic        req_full,
   input  logic [7:0]  req_text_char,
   input  logic        req_final_char,
   input  logic        rsp_empty,
   input  logic        rsp_pop,
   input  logic [3:0]  rsp_token_kind,
   input  logic [15:0] rsp_token_start,
   input  logic [15:0] rsp_token_length,
   input  logic [7:0]  rsp_bad_char,
   input  logic        rsp_last_in_run,
   output int          mismatch_count,
   output int          tokens_owed
);

   typedef struct packed {
      logic [3:0]  kind;
      logic [15:0] start;
      logic [15:0] length;
      logic [7:0]  bad;
      logic        last;
   } check_token_type;

   check_token_type owed_tokens[$];
   mode_type        scan_mode;
   logic [16:0]     text_pos;
   logic [15:0]     token_origin;
   int              errors;

   function automatic logic [7:0] fold_case(input logic [7:0] c);
      return (c >= CHAR_UP_A && c <= CHAR_UP_Z) ? c + CASE_GAP : c;
   endfunction

   function automatic logic is_blank(input logic [7:0] c);
      return c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR);
   endfunction

   function automatic logic is_dec(input logic [7:0] c);
      return c >= CHAR_ZERO && c <= CHAR_NINE;
   endfunction

   function automatic logic is_letter(input logic [7:0] c);
      return fold_case(c) >= CHAR_LO_A && fold_case(c) <= CHAR_LO_Z;
   endfunction

   function automatic logic is_hexdig(input logic [7:0] c);
      return is_dec(c) || (fold_case(c) >= CHAR_LO_A && fold_case(c) <= CHAR_LO_F);
   endfunction

   // error kind means not punctuation
   function automatic logic [3:0] punct_code(input logic [7:0] c);
      case (c)
         CHAR_DOT:   return KIND_DOT;
         CHAR_COMMA: return KIND_COMMA;
         CHAR_COLON: return KIND_COLON;
         CHAR_LSQ:   return KIND_LSQ;
         CHAR_RSQ:   return KIND_RSQ;
         default:    return KIND_ERROR;
      endcase
   endfunction

   function automatic check_token_type make_token(input logic [3:0] kind,
                                                  input logic [15:0] start,
                                                  input logic [15:0] length,
                                                  input logic [7:0] bad);
      check_token_type t;
      t.kind   = kind;
      t.start  = start;
      t.length = length;
      t.bad    = bad;
      t.last   = 1'b0;
      return t;
   endfunction

   task automatic tokenize_char(input logic [7:0] c, input logic fin);
      check_token_type made[$];
      logic [15:0]     run;
      logic [15:0]     here;
      logic [7:0]      lc;
      logic            rescan;
      here   = text_pos[15:0];
      run    = here - token_origin;
      lc     = fold_case(c);
      rescan = 1'b0;
      case (scan_mode)
         MODE_IDLE: rescan = 1'b1;
         MODE_COMMENT: begin
            if (c == CHAR_LF) scan_mode = MODE_IDLE;
         end
         MODE_STRING: begin
            if (fin || c == CHAR_QUOTE) begin
               made.push_back(make_token(KIND_STRING, token_origin, run - 16'd1, 8'd0));
               scan_mode = MODE_IDLE;
            end
         end
         MODE_SIGN, MODE_ZERO, MODE_BODY: begin
            if (!fin && scan_mode == MODE_SIGN && c == CHAR_ZERO) begin
               scan_mode = MODE_ZERO;
            end else if (!fin && scan_mode == MODE_ZERO &&
                         (lc == CHAR_LO_X || lc == CHAR_LO_B || lc == CHAR_LO_O)) begin
               scan_mode = MODE_BODY;
            end else if (!fin && is_hexdig(c)) begin
               scan_mode = MODE_BODY;
            end else begin
               made.push_back(make_token(KIND_NUMBER, token_origin, run, 8'd0));
               scan_mode = MODE_IDLE;
               rescan    = 1'b1;
            end
         end
         MODE_IDENT: begin
            if (fin || !(is_letter(c) || is_dec(c))) begin
               made.push_back(make_token(KIND_IDENT, token_origin, run, 8'd0));
               scan_mode = MODE_IDLE;
               rescan    = 1'b1;
            end
         end
         default: ;
      endcase

      if (rescan) begin
         if (!is_blank(c)) begin
            if (c == CHAR_NUL) begin
               made.push_back(make_token(KIND_END, here, 16'd0, 8'd0));
            end else if (c == CHAR_SEMI) begin
               scan_mode = MODE_COMMENT;
            end else if (punct_code(c) != KIND_ERROR) begin
               made.push_back(make_token(punct_code(c), here, 16'd1, 8'd0));
            end else if (c == CHAR_QUOTE) begin
               if (fin) made.push_back(make_token(KIND_STRING, here, 16'd0, 8'd0));
               else scan_mode = MODE_STRING;
            end else if (is_dec(c) || c == CHAR_MINUS) begin
               if (fin) made.push_back(make_token(KIND_NUMBER, here, 16'd1, 8'd0));
               else if (c == CHAR_MINUS) scan_mode = MODE_SIGN;
               else if (c == CHAR_ZERO) scan_mode = MODE_ZERO;
               else scan_mode = MODE_BODY;
            end else if (is_letter(c)) begin
               if (fin) made.push_back(make_token(KIND_IDENT, here, 16'd1, 8'd0));
               else scan_mode = MODE_IDENT;
            end else begin
               made.push_back(make_token(KIND_ERROR, here, 16'd1, c));
               scan_mode = MODE_ERROR;
            end
         end
         token_origin = here;
      end

      if (made.size() > 0) made[made.size() - 1].last = 1'b1;
      foreach (made[i]) owed_tokens.push_back(made[i]);

      if (fin) begin
         scan_mode    = MODE_IDLE;
         text_pos     = '0;
         token_origin = '0;
      end else if (text_pos < TEXT_LIMIT) begin
         text_pos = text_pos + 17'd1;
      end
   endtask

   always @(posedge clock) begin
      check_token_type got;
      check_token_type want;
      if (reset) begin
         scan_mode    = MODE_IDLE;
         text_pos     = '0;
         token_origin = '0;
         owed_tokens.delete();
         errors = 0;
      end else begin
         if (req_push && !req_full) tokenize_char(req_text_char, req_final_char);
         if (rsp_pop && !rsp_empty) begin
            got.kind   = rsp_token_kind;
            got.start  = rsp_token_start;
            got.length = rsp_token_length;
            got.bad    = rsp_bad_char;
            got.last   = rsp_last_in_run;
            if (owed_tokens.size() == 0) begin
               errors++;
               $display("%0t: token with none owed, expected nothing actual kind %0d start %0d",
                        $time, got.kind, got.start);
            end else begin
               want = owed_tokens.pop_front();
               if (got != want) errors++;
               if (got.kind != want.kind)
                  $display("%0t: token_kind expected %0d actual %0d",
                           $time, want.kind, got.kind);
               if (got.start != want.start)
                  $display("%0t: token_start expected %0d actual %0d",
                           $time, want.start, got.start);
               if (got.length != want.length)
                  $display("%0t: token_length expected %0d actual %0d",
                           $time, want.length, got.length);
               if (got.bad != want.bad)
                  $display("%0t: bad_char expected %0h actual %0h",
                           $time, want.bad, got.bad);
               if (got.last != want.last)
                  $display("%0t: last_in_run expected %0b actual %0b",
                           $time, want.last, got.last);
            end
         end
      end
      mismatch_count <= errors;
      tokens_owed    <= owed_tokens.size();
   end

endmodule

### tb/tb.sv
`timescale 1ns / 1ps

module tb
   import astu_pkg::*;
();

   localparam int TEXT_LIMIT   = 65536;
   localparam int RANDOM_ITEMS = 500;
   localparam int QUIET_LIMIT  = 2000;   // cycles with no transaction on either side
   localparam int DRAIN_CYCLES = 20;     // extra wait for characters still in flight

   logic        clock          = 1'b0;
   logic        reset          = 1'b1;
   logic        req_push       = 1'b0;
   logic        req_full;
   logic [7:0]  req_text_char  = 8'd0;
   logic        req_final_char = 1'b0;
   logic        rsp_empty;
   logic        rsp_pop        = 1'b0;
   logic [3:0]  rsp_token_kind;
   logic [15:0] rsp_token_start;
   logic [15:0] rsp_token_length;
   logic [7:0]  rsp_bad_char;
   logic        rsp_last_in_run;

   int          mismatches;
   int          tokens_owed;
   int          quiet_cycles = 0;
   logic        calm         = 1'b0;   // no idling on either side while set

   // character sets for building source text
   string       hex_set    = "0123456789abcdefABCDEF";
   string       letter_set = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ";
   string       alnum_set  = "abcxyzABCXYZ0123456789qQ";
   string       punct_set  = ".,:[]";
   string       blank_set  = " \t\n\v\f\r";
   string       prefix_set = "xXbBoO";
   string       odd_set    = "!#$%&'()*+/<=>?@\\^_{|}~";
   string       ending_set = "aZ09-\"; \n.,:[]x";

   logic [7:0]  text_q[$];   // characters of the text being sent, terminator last

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   assembly_source_tokenizer_unit #(
      .MAX_TEXT_LEN(TEXT_LIMIT)
   ) DUT (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_text_char   (req_text_char),
      .req_final_char  (req_final_char),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_token_kind  (rsp_token_kind),
      .rsp_token_start (rsp_token_start),
      .rsp_token_length(rsp_token_length),
      .rsp_bad_char    (rsp_bad_char),
      .rsp_last_in_run (rsp_last_in_run)
   );

   token_checker #(
      .TEXT_LIMIT(TEXT_LIMIT)
   ) u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_text_char   (req_text_char),
      .req_final_char  (req_final_char),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_token_kind  (rsp_token_kind),
      .rsp_token_start (rsp_token_start),
      .rsp_token_length(rsp_token_length),
      .rsp_bad_char    (rsp_bad_char),
      .rsp_last_in_run (rsp_last_in_run),
      .mismatch_count  (mismatches),
      .tokens_owed     (tokens_owed)
   );

   // token side: stall about 13 percent of the time unless calm
   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         rsp_pop <= calm || ($urandom_range(0, 99) >= 13);
      end
   end

   // watchdog: too long with no transaction on either side ends the run
   always @(posedge clock) begin
      if ((req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   function automatic logic [7:0] random_of(input string set);
      return set[$urandom_range(0, set.len() - 1)];
   endfunction

   function automatic logic [7:0] any_but(input logic [7:0] skip);
      logic [7:0] c;
      do c = 8'($urandom_range(0, 255)); while (c == skip);
      return c;
   endfunction

   // a byte that is no letter, digit, blank, quote, sign, punctuation or NUL
   function automatic logic [7:0] random_unknown();
      case ($urandom_range(0, 3))
         0:       return 8'($urandom_range(127, 255));
         1:       return 8'($urandom_range(14, 31));
         2:       return 8'($urandom_range(1, 8));
         default: return random_of(odd_set);
      endcase
   endfunction

   task automatic add_word(input string s);
      for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
   endtask

   // push the whole text, terminator flagged on the last transaction
   task automatic send_text();
      for (int i = 0; i < text_q.size(); i++) begin
         if (!calm && $urandom_range(0, 99) < 13) begin
            req_push <= 1'b0;
            @(posedge clock);
         end
         req_text_char  <= text_q[i];
         req_final_char <= (i == text_q.size() - 1);
         req_push       <= 1'b1;
         @(posedge clock);
         while (req_full) @(posedge clock);
      end
      text_q.delete();
   endtask

   // mostly well-formed token runs with random content, some noise and
   // broken endings; live gets the count of characters the block acts on
   task automatic compose_text(output int live);
      int   pieces;
      int   pick;
      int   n;
      logic open_end;
      live   = -1;
      pieces = $urandom_range(1, 8);
      for (int p = 0; p < pieces; p++) begin
         // last piece may stay open up to the terminator
         open_end = (p == pieces - 1) && ($urandom_range(0, 3) == 0);
         pick     = $urandom_range(0, 99);
         if (pick < 14) begin
            text_q.push_back(random_of(punct_set));
         end else if (pick < 26) begin
            // string, content any byte but the quote
            text_q.push_back(CHAR_QUOTE);
            n = $urandom_range(0, 6);
            repeat (n) text_q.push_back(any_but(CHAR_QUOTE));
            if (!open_end) text_q.push_back(CHAR_QUOTE);
         end else if (pick < 44) begin
            // number: sign, radix prefix, hex body, each optional
            if ($urandom_range(0, 1)) text_q.push_back(CHAR_MINUS);
            if ($urandom_range(0, 1)) begin
               text_q.push_back(CHAR_ZERO);
               if ($urandom_range(0, 1)) text_q.push_back(random_of(prefix_set));
            end
            n = $urandom_range(0, 5);
            repeat (n) text_q.push_back(random_of(hex_set));
         end else if (pick < 60) begin
            text_q.push_back(random_of(letter_set));
            n = $urandom_range(0, 6);
            repeat (n) text_q.push_back(random_of(alnum_set));
         end else if (pick < 70) begin
            n = $urandom_range(1, 3);
            repeat (n) text_q.push_back(random_of(blank_set));
         end else if (pick < 78) begin
            // comment up to and including line feed
            text_q.push_back(CHAR_SEMI);
            n = $urandom_range(0, 6);
            repeat (n) text_q.push_back(any_but(CHAR_LF));
            if (!open_end) text_q.push_back(CHAR_LF);
         end else if (pick < 86) begin
            text_q.push_back(CHAR_NUL);
         end else if (pick < 92) begin
            // error, then garbage the block skips
            if (live < 0) live = text_q.size() + 1;
            text_q.push_back(random_unknown());
            n = $urandom_range(0, 4);
            repeat (n) text_q.push_back(8'($urandom_range(0, 255)));
         end else begin
            n = $urandom_range(1, 4);
            repeat (n) text_q.push_back(8'($urandom_range(0, 255)));
         end
         if (!open_end && $urandom_range(0, 1)) text_q.push_back(random_of(blank_set));
      end

      // terminator: mostly NUL, else a byte of any class
      if ($urandom_range(0, 9) < 7) text_q.push_back(CHAR_NUL);
      else if ($urandom_range(0, 5) != 0) text_q.push_back(random_of(ending_set));
      else text_q.push_back(random_unknown());
      if (live < 0) live = text_q.size();
   endtask

   initial begin
      int live;
      int random_items;
      random_items = 0;

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // all kinds but dot and error: prefixed negative number, string, comment, identifier
      add_word("[-0x1F],\"a\";\n");
      add_word("Zz9:");
      text_q.push_back(CHAR_NUL);
      send_text();

      // byte above 127 is an error; the non-NUL terminator after it is dropped
      text_q.push_back(CHAR_DOT);
      text_q.push_back(8'hFF);
      text_q.push_back(CHAR_DOT);
      send_text();

      // string open at a non-NUL terminator is cut there
      add_word("\"xq");
      send_text();

      // random texts, with a stretch of full-rate traffic on both sides
      while (random_items < RANDOM_ITEMS) begin
         calm <= (random_items >= 200 && random_items < 320);
         compose_text(live);
         random_items += live;
         send_text();
      end

      req_push <= 1'b0;
      calm     <= 1'b0;
      @(posedge clock);
      while (tokens_owed != 0) @(posedge clock);
      // characters that give no token may still be in flight
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0 && tokens_owed == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

### sim.f
+incdir+sv
sv/astu_pkg.sv
sv/astu_front.sv
sv/astu_queue.sv
sv/astu_back.sv
sv/assembly_source_tokenizer_unit.sv
tb/token_checker.sv
tb/tb.sv
